@@ hw/rtl/mcrf_pkg.sv @@
// shared types and constants for the meter counter reset filter
// no dependencies

package mcrf_pkg;

   localparam int TIME_WIDTH    = 32;
   localparam int TIMEOUT_WIDTH = 16;

   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd300;

   // result flags; packed, so looped lands in tuser bit 0 and held in bit 1
   typedef struct packed {
      logic held;
      logic looped;
   } mcrf_flags_type;

endpackage

@@ hw/rtl/mcrf_core.sv @@
// filter state and per-word decision logic
// depends on mcrf_pkg

module mcrf_core
   import mcrf_pkg::*;
#(
   parameter int COUNT_WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [TIMEOUT_WIDTH-1:0] csr_wdata,
   input  logic                     fire,
   input  logic [COUNT_WIDTH-1:0]   reading,
   input  logic [TIME_WIDTH-1:0]    now_seconds,
   output logic [COUNT_WIDTH-1:0]   total,
   output mcrf_flags_type           flags
);

   logic [TIMEOUT_WIDTH-1:0] timeout_ff;
   logic [COUNT_WIDTH-1:0]   offset_ff, offset_in;
   logic [COUNT_WIDTH-1:0]   last_total_ff, last_total_in;
   logic                     reset_pending_ff, reset_pending_in;
   logic [COUNT_WIDTH-1:0]   pending_offset_ff, pending_offset_in;
   logic [TIME_WIDTH-1:0]    pending_since_ff, pending_since_in;

   logic [COUNT_WIDTH:0]     raw_sum, raw_alt;
   logic [COUNT_WIDTH-1:0]   sum, alt_sum;
   logic [TIME_WIDTH-1:0]    elapsed;
   logic                     reading_nz, low, in_window;

   // saturating sums against both the live and the pending offset
   assign raw_sum = {1'b0, offset_ff} + {1'b0, reading};
   assign raw_alt = {1'b0, pending_offset_ff} + {1'b0, reading};
   assign sum     = raw_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : raw_sum[COUNT_WIDTH-1:0];
   assign alt_sum = raw_alt[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : raw_alt[COUNT_WIDTH-1:0];

   assign reading_nz = |reading;
   assign low        = (sum < last_total_ff) && (|last_total_ff);
   assign elapsed    = now_seconds - pending_since_ff;
   assign in_window  = elapsed <= {{(TIME_WIDTH-TIMEOUT_WIDTH){1'b0}}, timeout_ff};

   always_comb begin
      offset_in         = offset_ff;
      last_total_in     = last_total_ff;
      reset_pending_in  = reset_pending_ff;
      pending_offset_in = pending_offset_ff;
      pending_since_in  = pending_since_ff;
      total             = last_total_ff;
      flags.held        = 1'b1;
      flags.looped      = 1'b0;
      if (reading_nz) begin
         if (reset_pending_ff) begin
            reset_pending_in = 1'b0;
            flags.held       = 1'b0;
            if (in_window && low) begin
               // confirmed counter reset
               flags.looped = 1'b1;
               offset_in    = pending_offset_ff;
               total        = alt_sum;
            end else begin
               total = sum;
            end
            last_total_in = total;
         end else if (low) begin
            reset_pending_in  = 1'b1;
            pending_offset_in = last_total_ff;
            pending_since_in  = now_seconds;
         end else begin
            flags.held    = 1'b0;
            total         = sum;
            last_total_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff        <= TIMEOUT_RESET;
         offset_ff         <= '0;
         last_total_ff     <= '0;
         reset_pending_ff  <= 1'b0;
         pending_offset_ff <= '0;
         pending_since_ff  <= '0;
      end else begin
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
         if (fire) begin
            offset_ff         <= offset_in;
            last_total_ff     <= last_total_in;
            reset_pending_ff  <= reset_pending_in;
            pending_offset_ff <= pending_offset_in;
            pending_since_ff  <= pending_since_in;
         end
      end
   end

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(flags.looped && flags.held))
      else $error("looped and held both set");

   a_pending_consumed: assert property (@(posedge clock) disable iff (reset)
      fire && reset_pending_ff && reading_nz |=> !reset_pending_ff)
      else $error("pending reset survived a nonzero reading");

   a_loop_offset: assert property (@(posedge clock) disable iff (reset)
      fire && flags.looped |=> offset_ff == $past(pending_offset_ff))
      else $error("offset not taken from pending record");

endmodule

@@ hw/rtl/meter_counter_reset_filter_unit.sv @@
// meter counter reset filter, top level: input stage, filter core and result register
// depends on mcrf_pkg and mcrf_core
// each req word passes the input register, then the result register (two register stages)
// throughput: one word per cycle; the filter state is updated in the single
//   cycle a word moves from the input register to the result register; rsp_tready low stalls
// reset: synchronous, active high; clears all filter state, sets the timeout to 300 s

module meter_counter_reset_filter_unit
   import mcrf_pkg::*;
#(
   parameter int COUNT_WIDTH = 48
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration: pending timeout in seconds
   input  logic                                    csr_we,
   input  logic [TIMEOUT_WIDTH-1:0]                csr_wdata,
   // input words
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((COUNT_WIDTH+TIME_WIDTH+7)/8)*8-1:0] req_tdata, // reading, now_seconds
   // result words
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((COUNT_WIDTH+7)/8)*8-1:0]        rsp_tdata,  // total
   output logic [1:0]                              rsp_tuser   // looped, held
);

   localparam int REQ_BITS = ((COUNT_WIDTH + TIME_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS = ((COUNT_WIDTH + 7) / 8) * 8;

   // input register
   logic                   in_valid_ff;
   logic [COUNT_WIDTH-1:0] in_reading_ff;
   logic [TIME_WIDTH-1:0]  in_now_ff;

   // result register
   logic                   out_valid_ff;
   logic [COUNT_WIDTH-1:0] out_total_ff;
   mcrf_flags_type         out_flags_ff;

   logic                   advance;
   logic                   req_fire;
   logic [COUNT_WIDTH-1:0] core_total;
   mcrf_flags_type         core_flags;

   // a word moves on when the result register is empty or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_reading_ff <= req_tdata[COUNT_WIDTH-1:0];
         in_now_ff     <= req_tdata[COUNT_WIDTH+TIME_WIDTH-1:COUNT_WIDTH];
      end
   end

   mcrf_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fire        (advance),
      .reading     (in_reading_ff),
      .now_seconds (in_now_ff),
      .total       (core_total),
      .flags       (core_flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_total_ff <= core_total;
         out_flags_ff <= core_flags;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_BITS'(out_total_ff);
   assign rsp_tuser  = {out_flags_ff.held, out_flags_ff.looped};

   // request word must hold both fields
   a_req_width: assert property (@(posedge clock) disable iff (reset)
      REQ_BITS >= COUNT_WIDTH + TIME_WIDTH)
      else $error("request word too narrow");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready && !advance |=> out_valid_ff)
      else $error("stalled result lost");

   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed word not presented");

endmodule
